// ===== hdl/srps_pkg.sv =====
package srps_pkg;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_EXPLICIT,
      PH_PREDICT
   } phase_type;

   typedef enum logic [2:0] {
      SQ_ACCEPT,
      SQ_DRD,
      SQ_DWR,
      SQ_ERD,
      SQ_EOUT
   } seq_type;

   typedef enum logic [1:0] {
      OP_START,
      OP_ENTRY,
      OP_FLAG,
      OP_RSVD
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_SET,
      ST_BAD_REF,
      ST_SEQ_ERR
   } status_type;

   localparam int OFF_W   = 21;
   localparam int DELTA_W = 17;

   localparam logic [OFF_W-1:0] OFF_MAX = 21'h0FFFFF;
   localparam logic [OFF_W-1:0] OFF_MIN = 21'h100000;

   // clamp a 22-bit signed sum to the 21-bit signed range
   function automatic logic [OFF_W-1:0] sat_off(input logic [OFF_W:0] v);
      logic [OFF_W-1:0] r;
      if (v[OFF_W] != v[OFF_W-1]) begin
         r = v[OFF_W] ? OFF_MIN : OFF_MAX;
      end else begin
         r = v[OFF_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/srps_ram.sv =====
module srps_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/short_term_rps_derivation_unit.sv =====
// short-term reference picture set builder
// req channel: one syntax item per transfer. a start item opens a set (explicit
// counts or prediction parameters), entry items carry explicit offsets, flag
// items carry used/keep flags of a predicted set.
// rsp channel: one result per transfer; every item gives at least one result,
// set_done marks the last result of a completed set.
// csr channel: writes the set count register, always ready; write it only
// while the block is idle.
// start, entry and non-final flag items are answered directly: the result is loaded
// into the output register in the cycle the item is taken.
// the final flag item of a predicted set starts derivation: each of the two
// passes walks nd+1 steps, the nd reference entries and the delta, through the
// single read port of the entry memory, with a read state and a write state per
// step; emission then reads each entry and loads it into the output register.
// req_ready is low during derivation and emission.
// synchronous reset clears the control state, the set count and the per-set
// list lengths; the entry memory is not cleared.
// a stalled rsp holds its result; req_ready stays low until the output
// register is free.
module short_term_rps_derivation_unit
   import srps_pkg::*;
#(
   parameter int NUM_SETS   = 32,
   parameter int MAX_DELTAS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_set_index,
   input  logic               req_predict_flag,
   input  logic [4:0]         req_count_negative,
   input  logic [4:0]         req_count_positive,
   input  logic [5:0]         req_delta_index_minus1,
   input  logic               req_delta_sign,
   input  logic [14:0]        req_delta_abs_minus1,
   input  logic [14:0]        req_offset_minus1,
   input  logic               req_used_flag,
   input  logic               req_use_delta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_entry_valid,
   output logic               rsp_list_select,
   output logic [3:0]         rsp_entry_index,
   output logic signed [20:0] rsp_poc_offset,
   output logic               rsp_entry_used,
   output logic               rsp_set_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [5:0]         csr_wdata
);

   localparam int SW    = $clog2(NUM_SETS);
   localparam int IW    = (MAX_DELTAS > 1) ? $clog2(MAX_DELTAS) : 1;
   localparam int CW    = $clog2(MAX_DELTAS + 1);
   localparam int FS    = 2 * MAX_DELTAS + 1;
   localparam int FW    = $clog2(FS);
   localparam int KW    = $clog2(FS + 1);
   localparam int AW    = SW + 1 + IW;
   localparam int DEPTH = 2 ** AW;
   localparam int DW    = OFF_W + 1;

   // control state
   seq_type   sq_ff, sq_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [5:0] set_count_ff;
   logic [CW-1:0] neg_tab_ff [NUM_SETS];
   logic [CW-1:0] pos_tab_ff [NUM_SETS];

   // working registers
   logic [SW-1:0]        cur_ff, cur_in;
   logic [SW-1:0]        ref_ff, ref_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 pass_ff, pass_in;
   logic [CW-1:0]        c0_ff, c0_in, c1_ff, c1_in;
   logic [CW-1:0]        neg_ff, neg_in, pos_ff, pos_in;
   logic [CW-1:0]        ref_nn_ff, ref_nn_in, ref_np_ff, ref_np_in;
   logic [DELTA_W-1:0]   delta_ff, delta_in;
   logic [OFF_W-1:0]     prev_ff, prev_in;
   logic [FS-1:0]        used_buf_ff, used_buf_in, keep_buf_ff, keep_buf_in;

   // output register payload
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_ev_ff, rsp_ev_in;
   logic             rsp_ls_ff, rsp_ls_in;
   logic [3:0]       rsp_idx_ff, rsp_idx_in;
   logic [OFF_W-1:0] rsp_off_ff, rsp_off_in;
   logic             rsp_used_ff, rsp_used_in;
   logic             rsp_done_ff, rsp_done_in;

   // count table write port
   logic          tab_we;
   logic [SW-1:0] tab_wa;
   logic [CW-1:0] tab_wn, tab_wp;

   // entry memory
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [DW-1:0] ram_wd, ram_rd;

   // decode
   opcode_type       op;
   logic             req_fire, out_free;
   logic             si_bad, ref_bad;
   logic [5:0]       d_sel;
   logic [6:0]       ref_full;
   logic [SW-1:0]    ref_idx;
   logic [CW-1:0]    cn_sat, cp_sat;
   logic [KW-1:0]    total_x, nd, ent_k;
   logic             ent_list, ent_last;
   logic [IW-1:0]    ent_idx;
   logic [OFF_W:0]   step, prev_s, ent_v;
   logic [OFF_W-1:0] ent_off;
   logic [CW-1:0]    first_n;
   logic             is_delta, src_list;
   logic [KW-1:0]    src_k, flag_k;
   logic [IW-1:0]    src_idx;
   logic [OFF_W-1:0] src_off;
   logic [OFF_W:0]   dv;
   logic             cond, app, step_last;
   logic [CW-1:0]    cur_c;
   logic [DELTA_W-1:0] mag;

   assign op        = opcode_type'(req_opcode);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (sq_ff == SQ_ACCEPT) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      si_bad   = 32'(req_set_index) >= NUM_SETS;
      d_sel    = (req_set_index == set_count_ff) ? req_delta_index_minus1 : 6'd0;
      ref_bad  = {1'b0, req_set_index} < ({1'b0, d_sel} + 7'd1);
      ref_full = {1'b0, req_set_index} - {1'b0, d_sel} - 7'd1;
      ref_idx  = ref_full[SW-1:0];
      cn_sat   = (6'(req_count_negative) > 6'(MAX_DELTAS)) ? CW'(MAX_DELTAS)
                                                            : CW'(req_count_negative);
      cp_sat   = (6'(req_count_positive) > 6'(MAX_DELTAS)) ? CW'(MAX_DELTAS)
                                                            : CW'(req_count_positive);
      mag      = DELTA_W'(req_delta_abs_minus1) + DELTA_W'(1);

      // explicit entry / emission position
      total_x  = KW'(neg_ff) + KW'(pos_ff);
      ent_list = k_ff >= KW'(neg_ff);
      ent_k    = ent_list ? k_ff - KW'(neg_ff) : k_ff;
      ent_idx  = ent_k[IW-1:0];
      ent_last = (k_ff + KW'(1)) >= total_x;
      step     = (OFF_W+1)'(req_offset_minus1) + (OFF_W+1)'(1);
      prev_s   = (ent_k == '0) ? '0 : {prev_ff[OFF_W-1], prev_ff};
      ent_v    = ent_list ? prev_s + step : prev_s - step;
      ent_off  = sat_off(ent_v);

      // derivation step: pass 0 builds the negative list, pass 1 the positive
      nd       = KW'(ref_nn_ff) + KW'(ref_np_ff);
      first_n  = pass_ff ? ref_nn_ff : ref_np_ff;
      is_delta = k_ff == KW'(first_n);
      if (k_ff < KW'(first_n)) begin
         src_list = !pass_ff;
         src_k    = KW'(first_n) - KW'(1) - k_ff;
      end else begin
         src_list = pass_ff;
         src_k    = k_ff - KW'(first_n) - KW'(1);
      end
      src_idx  = src_k[IW-1:0];
      if (is_delta) begin
         flag_k = nd;
      end else if (src_list) begin
         flag_k = KW'(ref_nn_ff) + src_k;
      end else begin
         flag_k = src_k;
      end
      src_off  = is_delta ? '0 : ram_rd[OFF_W-1:0];
      dv       = {src_off[OFF_W-1], src_off}
               + {{(OFF_W+1-DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
      cond     = pass_ff ? (!dv[OFF_W] && (dv != '0)) : dv[OFF_W];
      cur_c    = pass_ff ? c1_ff : c0_ff;
      app      = cond && keep_buf_ff[flag_k[FW-1:0]] && (cur_c < CW'(MAX_DELTAS));
      step_last = k_ff == nd;
   end

   // next state
   always_comb begin
      sq_in = sq_ff;
      case (sq_ff)
         SQ_ACCEPT: begin
            if (req_fire && (op == OP_FLAG) && (phase_ff == PH_PREDICT) && (k_ff >= nd)) begin
               sq_in = SQ_DRD;
            end
         end
         SQ_DRD: sq_in = SQ_DWR;
         SQ_DWR: begin
            sq_in = (step_last && pass_ff) ? SQ_ERD : SQ_DRD;
         end
         SQ_ERD: begin
            if (total_x == '0) begin
               if (out_free) begin
                  sq_in = SQ_ACCEPT;
               end
            end else begin
               sq_in = SQ_EOUT;
            end
         end
         SQ_EOUT: begin
            if (out_free) begin
               sq_in = ent_last ? SQ_ACCEPT : SQ_ERD;
            end
         end
         default: sq_in = SQ_ACCEPT;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in    = phase_ff;
      cur_in      = cur_ff;
      ref_in      = ref_ff;
      k_in        = k_ff;
      pass_in     = pass_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      neg_in      = neg_ff;
      pos_in      = pos_ff;
      ref_nn_in   = ref_nn_ff;
      ref_np_in   = ref_np_ff;
      delta_in    = delta_ff;
      prev_in     = prev_ff;
      used_buf_in = used_buf_ff;
      keep_buf_in = keep_buf_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_ls_in     = rsp_ls_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_done_in   = rsp_done_ff;

      tab_we = 1'b0;
      tab_wa = cur_ff;
      tab_wn = '0;
      tab_wp = '0;
      ram_we = 1'b0;
      ram_wa = {cur_ff, ent_list, ent_idx};
      ram_wd = {req_used_flag, ent_off};
      ram_re = 1'b0;
      ram_ra = {ref_ff, src_list, src_idx};

      case (sq_ff)
         SQ_ACCEPT: begin
            if (req_fire) begin
               // default result: plain acknowledge
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_ev_in     = 1'b0;
               rsp_ls_in     = 1'b0;
               rsp_idx_in    = '0;
               rsp_off_in    = '0;
               rsp_used_in   = 1'b0;
               rsp_done_in   = 1'b0;
               if ((op == OP_START) && (phase_ff == PH_IDLE)) begin
                  if (si_bad) begin
                     rsp_status_in = ST_BAD_SET;
                  end else if ((req_set_index == 6'd0) || !req_predict_flag) begin
                     cur_in = req_set_index[SW-1:0];
                     tab_we = 1'b1;
                     tab_wa = req_set_index[SW-1:0];
                     tab_wn = cn_sat;
                     tab_wp = cp_sat;
                     neg_in = cn_sat;
                     pos_in = cp_sat;
                     k_in   = '0;
                     if ((cn_sat == '0) && (cp_sat == '0)) begin
                        rsp_done_in = 1'b1;
                     end else begin
                        phase_in = PH_EXPLICIT;
                     end
                  end else if (ref_bad) begin
                     rsp_status_in = ST_BAD_REF;
                  end else begin
                     cur_in    = req_set_index[SW-1:0];
                     ref_in    = ref_idx;
                     ref_nn_in = neg_tab_ff[ref_idx];
                     ref_np_in = pos_tab_ff[ref_idx];
                     delta_in  = req_delta_sign ? -mag : mag;
                     phase_in  = PH_PREDICT;
                     k_in      = '0;
                  end
               end else if ((op == OP_ENTRY) && (phase_ff == PH_EXPLICIT)) begin
                  ram_we      = 1'b1;
                  prev_in     = ent_off;
                  k_in        = k_ff + KW'(1);
                  rsp_ev_in   = 1'b1;
                  rsp_ls_in   = ent_list;
                  rsp_idx_in  = 4'(ent_k);
                  rsp_off_in  = ent_off;
                  rsp_used_in = req_used_flag;
                  rsp_done_in = ent_last;
                  if (ent_last) begin
                     phase_in = PH_IDLE;
                  end
               end else if ((op == OP_FLAG) && (phase_ff == PH_PREDICT)) begin
                  used_buf_in[k_ff[FW-1:0]] = req_used_flag;
                  keep_buf_in[k_ff[FW-1:0]] = req_used_flag || req_use_delta;
                  k_in = k_ff + KW'(1);
                  if (k_ff >= nd) begin
                     // last flag: derivation takes over, result comes later
                     rsp_valid_in = 1'b0;
                     phase_in     = PH_IDLE;
                     k_in         = '0;
                     pass_in      = 1'b0;
                     c0_in        = '0;
                     c1_in        = '0;
                  end
               end else begin
                  rsp_status_in = ST_SEQ_ERR;
                  if (phase_ff != PH_IDLE) begin
                     tab_we   = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         SQ_DRD: begin
            ram_re = 1'b1;
         end
         SQ_DWR: begin
            ram_wa = {cur_ff, pass_ff, cur_c[IW-1:0]};
            ram_wd = {used_buf_ff[flag_k[FW-1:0]], sat_off(dv)};
            if (app) begin
               ram_we = 1'b1;
               if (pass_ff) begin
                  c1_in = c1_ff + CW'(1);
               end else begin
                  c0_in = c0_ff + CW'(1);
               end
            end
            if (step_last) begin
               k_in    = '0;
               pass_in = 1'b1;
               if (pass_ff) begin
                  tab_we = 1'b1;
                  tab_wn = c0_in;
                  tab_wp = c1_in;
                  neg_in = c0_in;
                  pos_in = c1_in;
               end
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         SQ_ERD: begin
            ram_ra = {cur_ff, ent_list, ent_idx};
            if (total_x == '0) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_ev_in     = 1'b0;
                  rsp_ls_in     = 1'b0;
                  rsp_idx_in    = '0;
                  rsp_off_in    = '0;
                  rsp_used_in   = 1'b0;
                  rsp_done_in   = 1'b1;
               end
            end else begin
               ram_re = 1'b1;
            end
         end
         SQ_EOUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_ev_in     = 1'b1;
               rsp_ls_in     = ent_list;
               rsp_idx_in    = 4'(ent_k);
               rsp_off_in    = ram_rd[OFF_W-1:0];
               rsp_used_in   = ram_rd[OFF_W];
               rsp_done_in   = ent_last;
               k_in          = k_ff + KW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff        <= SQ_ACCEPT;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         set_count_ff <= '0;
         k_ff         <= '0;
         for (int i = 0; i < NUM_SETS; i++) begin
            neg_tab_ff[i] <= '0;
            pos_tab_ff[i] <= '0;
         end
      end else begin
         sq_ff        <= sq_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         if (csr_valid) begin
            set_count_ff <= csr_wdata;
         end
         if (tab_we) begin
            neg_tab_ff[tab_wa] <= tab_wn;
            pos_tab_ff[tab_wa] <= tab_wp;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      ref_ff        <= ref_in;
      pass_ff       <= pass_in;
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
      neg_ff        <= neg_in;
      pos_ff        <= pos_in;
      ref_nn_ff     <= ref_nn_in;
      ref_np_ff     <= ref_np_in;
      delta_ff      <= delta_in;
      prev_ff       <= prev_in;
      used_buf_ff   <= used_buf_in;
      keep_buf_ff   <= keep_buf_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_ls_ff     <= rsp_ls_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_done_ff   <= rsp_done_in;
   end

   srps_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_valid = rsp_ev_ff;
   assign rsp_list_select = rsp_ls_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_poc_offset  = $signed(rsp_off_ff);
   assign rsp_entry_used  = rsp_used_ff;
   assign rsp_set_done    = rsp_done_ff;

endmodule

// ===== hdl/srps_checker.sv =====
module srps_checker
   import srps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic               rsp_entry_valid,
   input logic               rsp_list_select,
   input logic [3:0]         rsp_entry_index,
   input logic signed [20:0] rsp_poc_offset,
   input logic               rsp_entry_used,
   input logic               rsp_set_done
);

   // a pending result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped before transfer");

   // results without an entry carry zero entry fields
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> (rsp_poc_offset == '0) && !rsp_entry_used
         && !rsp_list_select && (rsp_entry_index == '0))
      else $error("entry fields set on result without entry");

   // error results neither carry an entry nor complete a set
   a_error_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> !rsp_entry_valid && !rsp_set_done)
      else $error("error result with entry or done");

   // nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind short_term_rps_derivation_unit srps_checker u_srps_checker (.*);
